// ===== hdl/afsk_pkg.sv =====
// ----------------------------------------------------------------------------
// AFSK HDLC transmitter package
// Shared constants, operation and register codes, state types and sine lookup.
// ----------------------------------------------------------------------------
package afsk_pkg;

    localparam int BIT_FIFO_DEPTH_DEF = 8192;
    localparam int FRAME_BYTES_DEF    = 512;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [2:0] STUFF_RUN  = 3'd5;
    localparam logic [3:0] IDLE_LEVEL = 4'd8;
    localparam logic [3:0] END_LEVEL  = 4'd7;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_PREAMBLE = 3'd0,
        REG_TAIL     = 3'd1,
        REG_SPB      = 3'd2,
        REG_MARK     = 3'd3,
        REG_SPACE    = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_SCAN_HEAD,
        ST_SCAN_HEAD_W,
        ST_SCAN_TAIL,
        ST_SCAN_TAIL_W,
        ST_FRAME_RD,
        ST_FRAME_W,
        ST_FRAME_BIT,
        ST_TAIL,
        ST_TICK_W,
        ST_DONE
    } t_state;

    function automatic logic [3:0] sine_lookup(input logic [3:0] idx);
        logic [3:0] v;
        unique case (idx)
            4'd0:  v = 4'd8;
            4'd1:  v = 4'd11;
            4'd2:  v = 4'd13;
            4'd3:  v = 4'd14;
            4'd4:  v = 4'd15;
            4'd5:  v = 4'd14;
            4'd6:  v = 4'd13;
            4'd7:  v = 4'd11;
            4'd8:  v = 4'd8;
            4'd9:  v = 4'd5;
            4'd10: v = 4'd2;
            4'd11: v = 4'd1;
            4'd12: v = 4'd0;
            4'd13: v = 4'd1;
            4'd14: v = 4'd2;
            default: v = 4'd5;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/afsk_ram.sv =====
// ----------------------------------------------------------------------------
// AFSK generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module afsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/afsk_hdlc_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// AFSK HDLC transmitter
// Frame store, bit stream builder with flags and bit stuffing, NRZI AFSK
// playout from a bit FIFO.
// ----------------------------------------------------------------------------
//  channel  | signals                                     | direction
//  ---------+---------------------------------------------+----------
//  input    | i_valid/o_stall, i_operation, i_data_byte,  | in
//           | i_last_byte                                 |
//  output   | o_valid/i_stall, o_dac_value, o_dac_valid,  | out
//           | o_busy_res, o_bits_remaining, o_overflow    |
//  config   | APB psel/penable/pwrite/paddr/pwdata/prdata | in/out
//
// Start, stop, non-final bytes and ticks inside a bit pass through ST_DONE,
// which marks the result valid. Ticks that take a new bit pass ST_TICK_W first
// (one bit FIFO read). A final byte walks the frame store and writes the bit
// FIFO one bit per cycle: preamble flags, frame bytes without leading and
// trailing flag bytes, stuffed zeros, then tail flags.
// Reset is synchronous; the memories are not cleared. One transaction is in
// flight at a time; o_stall is high until the result register is empty.
// ----------------------------------------------------------------------------
module afsk_hdlc_transmitter_top #(
    parameter int BIT_FIFO_DEPTH = afsk_pkg::BIT_FIFO_DEPTH_DEF,
    parameter int FRAME_BYTES    = afsk_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_dac_value,
    output logic        o_dac_valid,
    output logic        o_busy_res,
    output logic [13:0] o_bits_remaining,
    output logic        o_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import afsk_pkg::*;

    localparam int BAW = $clog2(BIT_FIFO_DEPTH);
    localparam int FAW = $clog2(FRAME_BYTES);
    localparam int BCW = BAW + 1;
    localparam int FCW = FAW + 1;

    // configuration registers
    logic [5:0]  r_pre;
    logic [3:0]  r_tailf;
    logic [3:0]  r_spb;
    logic [11:0] r_mark;
    logic [11:0] r_space;
    t_reg        w_reg;
    logic        w_cfg_we;

    assign pready   = 1'b1;
    assign w_reg    = t_reg'(paddr[4:2]);
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= 6'd30;
            r_tailf <= 4'd3;
            r_spb   <= 4'd8;
            r_mark  <= 12'd512;
            r_space <= 12'd939;
        end else if (w_cfg_we) begin
            unique case (w_reg)
                REG_PREAMBLE: r_pre   <= pwdata[5:0];
                REG_TAIL:     r_tailf <= pwdata[3:0];
                REG_SPB:      r_spb   <= pwdata[3:0];
                REG_MARK:     r_mark  <= pwdata[11:0];
                REG_SPACE:    r_space <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (w_reg)
            REG_PREAMBLE: prdata = {26'd0, r_pre};
            REG_TAIL:     prdata = {28'd0, r_tailf};
            REG_SPB:      prdata = {28'd0, r_spb};
            REG_MARK:     prdata = {20'd0, r_mark};
            REG_SPACE:    prdata = {20'd0, r_space};
            default:      prdata = 32'd0;
        endcase
    end

    // block state
    t_state         r_state, n_state;
    logic [BAW-1:0] r_head, r_tailp;
    logic [BCW-1:0] r_count;
    logic [FCW-1:0] r_fill;
    logic           r_mark_tone;
    logic [15:0]    r_phase;
    logic [11:0]    r_step;
    logic [3:0]     r_left;
    logic           r_run;
    logic [2:0]     r_ones;
    logic           r_ovf;
    logic [5:0]     r_fcnt;    // flag byte counter
    logic [2:0]     r_bit;     // bit within byte
    logic [FCW-1:0] r_first, r_stop, r_idx;
    logic [7:0]     r_byte;
    logic           r_stuff;   // stuffed zero pending
    logic [3:0]     r_res_dac;
    logic           r_res_dv;
    logic           r_oval;

    // memories
    logic           w_bwe, w_bdin, w_bdout;
    logic [FAW-1:0] w_fra;
    logic [7:0]     w_frd;
    logic           w_fwe;

    afsk_ram #(.WIDTH(1), .DEPTH(BIT_FIFO_DEPTH)) u_bits (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(r_head), .i_wdata(w_bdin),
        .i_raddr(r_tailp), .o_rdata(w_bdout)
    );

    afsk_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(r_fill[FAW-1:0]), .i_wdata(i_data_byte),
        .i_raddr(w_fra), .o_rdata(w_frd)
    );

    logic w_acc;
    assign o_stall = (r_state != ST_IDLE) || r_oval;
    assign w_acc   = i_valid && !o_stall;
    assign w_fwe   = w_acc && t_op'(i_operation) == OP_BYTE && r_fill < FCW'(FRAME_BYTES);

    // current bit to push (flag or data)
    logic w_flagbit, w_databit, w_push_ok;
    assign w_flagbit = FLAG_BYTE[r_bit];
    assign w_databit = r_stuff ? 1'b0 : r_byte[r_bit];
    assign w_push_ok = r_count < BCW'(BIT_FIFO_DEPTH);

    always_comb begin
        unique case (r_state)
            ST_SCAN_HEAD:   w_fra = r_first[FAW-1:0];
            ST_SCAN_TAIL:   w_fra = FAW'(r_stop - 1'b1);
            default:        w_fra = r_idx[FAW-1:0];
        endcase
    end

    always_comb begin
        w_bwe  = 1'b0;
        w_bdin = 1'b0;
        unique case (r_state)
            ST_PRE, ST_TAIL: begin
                w_bwe = (r_fcnt != 6'd0) && w_push_ok;
                w_bdin = w_flagbit;
            end
            ST_FRAME_BIT: begin
                w_bwe = w_push_ok;
                w_bdin = w_databit;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_acc) begin
                priority if (t_op'(i_operation) == OP_TICK && r_run && r_left == 4'd0
                             && r_count != '0)
                    n_state = ST_TICK_W;
                else if (t_op'(i_operation) == OP_BYTE && i_last_byte)
                    n_state = ST_PRE;
                else
                    n_state = ST_DONE;
            end
            ST_PRE:         if (r_fcnt == 6'd0) n_state = ST_SCAN_HEAD;
            ST_SCAN_HEAD:   n_state = (r_first < r_stop) ? ST_SCAN_HEAD_W : ST_FRAME_RD;
            ST_SCAN_HEAD_W: n_state = (w_frd == FLAG_BYTE) ? ST_SCAN_HEAD : ST_SCAN_TAIL;
            ST_SCAN_TAIL:   n_state = (r_stop > r_first) ? ST_SCAN_TAIL_W : ST_FRAME_RD;
            ST_SCAN_TAIL_W: n_state = (w_frd == FLAG_BYTE) ? ST_SCAN_TAIL : ST_FRAME_RD;
            ST_FRAME_RD:    n_state = (r_idx < r_stop) ? ST_FRAME_W : ST_TAIL;
            ST_FRAME_W:     n_state = ST_FRAME_BIT;
            ST_FRAME_BIT: begin
                if (!r_stuff && !(r_byte[r_bit] && r_ones == STUFF_RUN - 3'd1)
                    && r_bit == 3'd7)
                    n_state = ST_FRAME_RD;
                else if (r_stuff && r_bit == 3'd7)
                    n_state = ST_FRAME_RD;
            end
            ST_TAIL:        if (r_fcnt == 6'd0) n_state = ST_DONE;
            ST_TICK_W:      n_state = ST_DONE;
            ST_DONE:        n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    logic       w_nmark;
    logic [3:0] w_spb1;
    assign w_nmark = w_bdout ? r_mark_tone : !r_mark_tone;
    assign w_spb1  = (r_spb == 4'd0) ? 4'd1 : r_spb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tailp     <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_mark_tone <= 1'b1;
            r_phase     <= '0;
            r_step      <= 12'd512;
            r_left      <= '0;
            r_run       <= 1'b0;
            r_ones      <= '0;
            r_ovf       <= 1'b0;
            r_oval      <= 1'b0;
            r_fcnt      <= '0;
            r_bit       <= '0;
            r_stuff     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) r_oval <= 1'b0;
            if (w_bwe) begin
                r_head  <= r_head + 1'b1;
                r_count <= r_count + 1'b1;
            end
            unique case (r_state)
                ST_IDLE: if (w_acc) begin
                    unique case (t_op'(i_operation))
                        OP_BYTE: begin
                            r_res_dac <= 4'd0;
                            r_res_dv  <= 1'b0;
                            if (r_fill == '0 || r_fill >= FCW'(FRAME_BYTES))
                                r_ovf <= (r_fill >= FCW'(FRAME_BYTES));
                            if (r_fill < FCW'(FRAME_BYTES)) r_fill <= r_fill + 1'b1;
                            if (i_last_byte) begin
                                r_head      <= '0;
                                r_tailp     <= '0;
                                r_count     <= '0;
                                r_mark_tone <= 1'b1;
                                r_step      <= r_mark;
                                r_phase     <= '0;
                                r_left      <= '0;
                                r_ones      <= '0;
                                r_fcnt      <= r_pre;
                                r_bit       <= '0;
                                r_first     <= '0;
                                r_stop      <= (r_fill < FCW'(FRAME_BYTES)) ?
                                               r_fill + 1'b1 : r_fill;
                            end
                        end
                        OP_START: begin
                            r_run     <= 1'b1;
                            r_res_dac <= 4'd0;
                            r_res_dv  <= 1'b0;
                        end
                        OP_STOP: begin
                            r_run     <= 1'b0;
                            r_res_dac <= IDLE_LEVEL;
                            r_res_dv  <= 1'b1;
                        end
                        default: begin
                            r_res_dv <= 1'b1;
                            if (!r_run) begin
                                r_res_dac <= IDLE_LEVEL;
                            end else if (r_left == 4'd0 && r_count == '0) begin
                                r_run     <= 1'b0;
                                r_res_dac <= END_LEVEL;
                            end else if (r_left != 4'd0) begin
                                r_res_dac <= sine_lookup(r_phase[11:8]);
                                r_phase   <= r_phase + 16'(r_step);
                                r_left    <= r_left - 1'b1;
                            end
                        end
                    endcase
                end
                ST_TICK_W: begin
                    r_tailp     <= r_tailp + 1'b1;
                    r_count     <= r_count - 1'b1;
                    r_mark_tone <= w_nmark;
                    r_step      <= w_nmark ? r_mark : r_space;
                    r_left      <= w_spb1 - 1'b1;
                    r_res_dac   <= sine_lookup(r_phase[11:8]);
                    r_phase     <= r_phase + 16'(w_nmark ? r_mark : r_space);
                end
                ST_PRE, ST_TAIL: if (r_fcnt != 6'd0) begin
                    if (!w_push_ok) r_ovf <= 1'b1;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 3'd7) r_fcnt <= r_fcnt - 1'b1;
                end
                ST_SCAN_HEAD_W: if (w_frd == FLAG_BYTE) r_first <= r_first + 1'b1;
                ST_SCAN_TAIL_W: if (w_frd == FLAG_BYTE) r_stop <= r_stop - 1'b1;
                ST_FRAME_RD: begin
                    r_fcnt <= {2'b00, r_tailf};
                    r_bit  <= '0;
                    if (r_idx >= r_stop) r_fill <= '0;
                end
                ST_FRAME_W: begin
                    r_byte  <= w_frd;
                    r_idx   <= r_idx + 1'b1;
                    r_stuff <= 1'b0;
                end
                ST_FRAME_BIT: begin
                    if (!w_push_ok) r_ovf <= 1'b1;
                    if (r_stuff) begin
                        r_stuff <= 1'b0;
                        r_ones  <= '0;
                        r_bit   <= r_bit + 1'b1;
                    end else if (r_byte[r_bit]) begin
                        if (r_ones == STUFF_RUN - 3'd1) begin
                            r_stuff <= 1'b1;
                        end else begin
                            r_ones <= r_ones + 1'b1;
                            r_bit  <= r_bit + 1'b1;
                        end
                    end else begin
                        r_ones <= '0;
                        r_bit  <= r_bit + 1'b1;
                    end
                end
                ST_DONE: r_oval <= 1'b1;
                default: ;
            endcase
            if (r_state == ST_PRE && r_fcnt == 6'd0) begin
                r_ones <= '0;
                r_idx  <= '0;
            end
            if (r_state == ST_SCAN_TAIL && !(r_stop > r_first)) r_idx <= r_first;
            if (r_state == ST_SCAN_TAIL_W && w_frd != FLAG_BYTE) r_idx <= r_first;
            if (r_state == ST_SCAN_HEAD && !(r_first < r_stop)) r_idx <= r_first;
        end
    end

    assign o_valid          = r_oval;
    assign o_dac_value      = r_res_dac;
    assign o_dac_valid      = r_res_dv;
    assign o_busy_res       = r_run || (r_count != '0);
    assign o_bits_remaining = 14'(r_count);
    assign o_overflow       = r_ovf;
endmodule
